@@ hw/rtl/pta_pkg.sv @@
// Shared constants, register codes and types for the pulse amplitude and pileup block.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package pta_pkg;

  // Fixed field widths of the channels and the configuration port.
  localparam int SAMPLE_W    = 14;
  localparam int AMP_W       = 22;
  localparam int INDEX_W     = 12;
  localparam int DISCARD_W   = 12;
  localparam int DURATION_W  = 12;
  localparam int THRESH_W    = 14;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 14;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_LIMIT   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PULSE_DURATION = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DIP_THRESHOLD  = 2'd2;

  // Register reset values.
  localparam logic [DISCARD_W-1:0]  RST_OFFSET_LIMIT   = 12'd4095;
  localparam logic [DURATION_W-1:0] RST_PULSE_DURATION = 12'd30;
  localparam logic [THRESH_W-1:0]   RST_DIP_THRESHOLD  = 14'd50;

  // Default values of the top-level parameters.
  localparam int DEF_SAMPLE_BITS   = 14;
  localparam int DEF_PREGATE       = 25;
  localparam int DEF_NEIGHBOUR_GAP = 6;
  localparam int DEF_TRACE_CAP     = 4096;

  // Status that travels with a finished trace from the front end to the result stages.
  typedef struct packed {
    logic valid;
    logic pileup;
    logic short_tr;
  } pta_snap_t;

endpackage

`default_nettype wire

@@ hw/rtl/pta_if.sv @@
// Valid/ready channel interfaces for the sample stream and the result stream.
// Depends on pta_pkg for the payload widths.
`default_nettype none

interface pta_in_if;
  logic                         valid;
  logic                         ready;
  logic [pta_pkg::SAMPLE_W-1:0] sample;
  logic                         last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface pta_out_if;
  logic                        valid;
  logic                        ready;
  logic [pta_pkg::AMP_W-1:0]   amplitude_q8;
  logic [pta_pkg::INDEX_W-1:0] min_index;
  logic                        offset_flag;
  logic                        pileup_flag;
  logic                        short_trace;

  modport source (output valid, output amplitude_q8, output min_index, output offset_flag,
                  output pileup_flag, output short_trace, input ready);
  modport sink   (input valid, input amplitude_q8, input min_index, input offset_flag,
                  input pileup_flag, input short_trace, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pulse_trace_amplitude_pileup.sv @@
// Top level of the pulse amplitude and pileup block: configuration registers and the two stages.
// Depends on pta_pkg, pta_if, pta_trace and pta_result.
//
//   channel   | direction | payload                                          | handshake
//   in_chan   | in        | sample[13:0], last_sample                        | valid/ready
//   out_chan  | out       | amplitude_q8[21:0], min_index[11:0], 3 flags     | valid/ready
//   cfg_*     | in        | cfg_index[1:0], cfg_data[13:0]                   | cfg_we only
//
// One sample is taken every cycle while in_chan.ready is high; the sustained rate is one
// item per clock, set by the combinational window compare and minimum update in the front end.
// A trace's result passes through the snapshot, product and output registers in turn.
// Reset is synchronous and active low; it clears the trace state and loads register defaults.
// While the output is stalled, up to three finished traces wait in the snapshot and the result
// stages; only when all three are full does in_chan.ready drop.
`default_nettype none

module pulse_trace_amplitude_pileup #(
  parameter int SAMPLE_BITS   = pta_pkg::DEF_SAMPLE_BITS,
  parameter int PREGATE       = pta_pkg::DEF_PREGATE,
  parameter int NEIGHBOUR_GAP = pta_pkg::DEF_NEIGHBOUR_GAP,
  parameter int TRACE_CAP     = pta_pkg::DEF_TRACE_CAP
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  pta_in_if.sink                                 in_chan,
  pta_out_if.source                              out_chan,
  input  wire logic                              cfg_we,
  input  wire logic [pta_pkg::CFG_ADDR_W-1:0]    cfg_index,
  input  wire logic [pta_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pta_pkg::*;

  localparam int IW = $clog2(TRACE_CAP);
  localparam int BW = SAMPLE_BITS + $clog2(PREGATE);

  logic [DISCARD_W-1:0]  offset_limit_r;
  logic [DURATION_W-1:0] pulse_duration_r;
  logic [THRESH_W-1:0]   dip_threshold_r;

  pta_snap_t              snap;
  logic [BW-1:0]          snap_sum;
  logic [SAMPLE_BITS-1:0] snap_min;
  logic [IW-1:0]          snap_pos;
  logic                   snap_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_limit_r   <= RST_OFFSET_LIMIT;
      pulse_duration_r <= RST_PULSE_DURATION;
      dip_threshold_r  <= RST_DIP_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_LIMIT:   offset_limit_r   <= cfg_data[DISCARD_W-1:0];
        REG_PULSE_DURATION: pulse_duration_r <= cfg_data[DURATION_W-1:0];
        REG_DIP_THRESHOLD:  dip_threshold_r  <= cfg_data[THRESH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pta_trace #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .PREGATE       (PREGATE),
    .NEIGHBOUR_GAP (NEIGHBOUR_GAP),
    .TRACE_CAP     (TRACE_CAP)
  ) u_trace (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_chan        (in_chan),
    .dip_threshold  (dip_threshold_r),
    .pulse_duration (pulse_duration_r),
    .snap_ready     (snap_ready),
    .snap           (snap),
    .snap_sum       (snap_sum),
    .snap_min       (snap_min),
    .snap_pos       (snap_pos)
  );

  pta_result #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .PREGATE     (PREGATE),
    .TRACE_CAP   (TRACE_CAP)
  ) u_result (
    .clk          (clk),
    .rst_n        (rst_n),
    .snap         (snap),
    .snap_sum     (snap_sum),
    .snap_min     (snap_min),
    .snap_pos     (snap_pos),
    .offset_limit (offset_limit_r),
    .snap_ready   (snap_ready),
    .out_chan     (out_chan)
  );

endmodule

`default_nettype wire

@@ hw/rtl/pta_trace.sv @@
// Per-sample front end: baseline sum, running minimum, dip window and pileup tracking.
// Holds a snapshot of the finished trace for the result stages. Uses pta_pkg and pta_in_if.
`default_nettype none

module pta_trace #(
  parameter int SAMPLE_BITS   = pta_pkg::DEF_SAMPLE_BITS,
  parameter int PREGATE       = pta_pkg::DEF_PREGATE,
  parameter int NEIGHBOUR_GAP = pta_pkg::DEF_NEIGHBOUR_GAP,
  parameter int TRACE_CAP     = pta_pkg::DEF_TRACE_CAP,
  localparam int IW = $clog2(TRACE_CAP),
  localparam int BW = SAMPLE_BITS + $clog2(PREGATE)
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  pta_in_if.sink                                  in_chan,
  input  wire logic [pta_pkg::THRESH_W-1:0]       dip_threshold,
  input  wire logic [pta_pkg::DURATION_W-1:0]     pulse_duration,
  input  wire logic                               snap_ready,
  output pta_pkg::pta_snap_t                      snap,
  output logic      [BW-1:0]                      snap_sum,
  output logic      [SAMPLE_BITS-1:0]             snap_min,
  output logic      [IW-1:0]                      snap_pos
);
  import pta_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int NG  = NEIGHBOUR_GAP;
  localparam int CW  = ((IW > 9) ? IW : 9) + 1;
  localparam int DW  = ((SB > THRESH_W) ? SB : THRESH_W) + 1;
  localparam int GW  = (IW > DURATION_W) ? IW : DURATION_W;
  localparam logic [IW-1:0] CNT_MAX = IW'(TRACE_CAP - 1);

  // Shift line of the last 2*NG samples; index 0 is the newest.
  logic [SB-1:0] win_r [2*NG];

  logic [BW-1:0] sum_r;
  logic [SB-1:0] min_r;
  logic [IW-1:0] pos_r;
  logic [IW-1:0] cnt_r;
  logic [IW-1:0] prev_pos_r;
  logic          prev_valid_r;
  logic          pileup_r;

  logic          snap_v_r;
  logic          snap_pileup_r;
  logic          snap_short_r;
  logic [BW-1:0] snap_sum_r;
  logic [SB-1:0] snap_min_r;
  logic [IW-1:0] snap_pos_r;

  logic [SB+SAMPLE_W-1:0] s_ext;
  logic [SB-1:0]          s;
  logic                   accept;
  logic [CW-1:0]          n_ext;
  logic                   in_pregate;
  logic                   win_full;
  logic [DW-1:0]          ctr_thr;
  logic                   is_dip;
  logic [IW-1:0]          dip_pos;
  logic [IW-1:0]          gap;
  logic                   late;
  logic                   take_min;

  logic [BW-1:0] sum_nxt;
  logic [SB-1:0] min_nxt;
  logic [IW-1:0] pos_nxt;
  logic [IW-1:0] cnt_nxt;
  logic [IW-1:0] prev_pos_nxt;
  logic          prev_valid_nxt;
  logic          pileup_nxt;
  logic          short_nxt;

  assign s_ext = {{SB{1'b0}}, in_chan.sample};
  assign s     = s_ext[SB-1:0];

  assign in_chan.ready = !snap_v_r || snap_ready;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    n_ext      = CW'(cnt_r);
    in_pregate = n_ext < CW'(PREGATE);
    win_full   = n_ext >= CW'(2 * NG);

    // The centre is the sample NG back, the left neighbour 2*NG back, the right one is new.
    ctr_thr = DW'(win_r[NG-1]) + DW'(dip_threshold);
    is_dip  = win_full && !pileup_r &&
              (DW'(win_r[2*NG-1]) > ctr_thr) && (DW'(s) > ctr_thr);
    dip_pos = cnt_r - IW'(NG);
    gap     = dip_pos - prev_pos_r;
    late    = GW'(gap) > GW'(pulse_duration);

    pileup_nxt     = pileup_r || (is_dip && prev_valid_r && late);
    prev_pos_nxt   = is_dip ? dip_pos : prev_pos_r;
    prev_valid_nxt = prev_valid_r || is_dip;

    take_min = s < min_r;
    min_nxt  = take_min ? s : min_r;
    pos_nxt  = take_min ? cnt_r : pos_r;
    sum_nxt  = in_pregate ? (sum_r + BW'(s)) : sum_r;
    cnt_nxt  = (cnt_r != CNT_MAX) ? (cnt_r + 1'b1) : cnt_r;

    short_nxt = (n_ext + 1'b1) < CW'(PREGATE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r        <= '0;
      min_r        <= '1;
      pos_r        <= '0;
      cnt_r        <= '0;
      prev_pos_r   <= '0;
      prev_valid_r <= 1'b0;
      pileup_r     <= 1'b0;
      snap_v_r     <= 1'b0;
    end else begin
      if (accept) begin
        if (in_chan.last_sample) begin
          sum_r        <= '0;
          min_r        <= '1;
          pos_r        <= '0;
          cnt_r        <= '0;
          prev_pos_r   <= '0;
          prev_valid_r <= 1'b0;
          pileup_r     <= 1'b0;
        end else begin
          sum_r        <= sum_nxt;
          min_r        <= min_nxt;
          pos_r        <= pos_nxt;
          cnt_r        <= cnt_nxt;
          prev_pos_r   <= prev_pos_nxt;
          prev_valid_r <= prev_valid_nxt;
          pileup_r     <= pileup_nxt;
        end
      end
      if (accept && in_chan.last_sample) begin
        snap_v_r <= 1'b1;
      end else if (snap_ready) begin
        snap_v_r <= 1'b0;
      end
    end
  end

  // The window only feeds the dip test once it holds 2*NG samples of the current trace.
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r[0] <= s;
      for (int k = 1; k < 2 * NG; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_chan.last_sample) begin
      snap_sum_r    <= sum_nxt;
      snap_min_r    <= min_nxt;
      snap_pos_r    <= pos_nxt;
      snap_pileup_r <= pileup_nxt;
      snap_short_r  <= short_nxt;
    end
  end

  assign snap.valid    = snap_v_r;
  assign snap.pileup   = snap_pileup_r;
  assign snap.short_tr = snap_short_r;
  assign snap_sum      = snap_sum_r;
  assign snap_min      = snap_min_r;
  assign snap_pos      = snap_pos_r;

`ifndef SYNTHESIS
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_chan.last_sample |=> snap_v_r && (cnt_r == '0) && !pileup_r)
    else $error("trace end did not load the snapshot and clear the trace state");

  a_snap_holds: assert property (@(posedge clk) disable iff (!rst_n)
    snap_v_r && !snap_ready |=> snap_v_r && $stable(snap_pos_r) && $stable(snap_sum_r))
    else $error("stalled snapshot changed");

  a_pileup_needs_dip: assert property (@(posedge clk) disable iff (!rst_n)
    pileup_r |-> prev_valid_r)
    else $error("pileup flagged without an earlier dip");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/pta_result.sv @@
// Result stages: baseline mean by reciprocal multiply, amplitude, flags and output register.
// Uses pta_pkg and pta_out_if; fed by the snapshot of pta_trace.
`default_nettype none

module pta_result #(
  parameter int SAMPLE_BITS = pta_pkg::DEF_SAMPLE_BITS,
  parameter int PREGATE     = pta_pkg::DEF_PREGATE,
  parameter int TRACE_CAP   = pta_pkg::DEF_TRACE_CAP,
  localparam int IW = $clog2(TRACE_CAP),
  localparam int BW = SAMPLE_BITS + $clog2(PREGATE)
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire pta_pkg::pta_snap_t              snap,
  input  wire logic [BW-1:0]                   snap_sum,
  input  wire logic [SAMPLE_BITS-1:0]          snap_min,
  input  wire logic [IW-1:0]                   snap_pos,
  input  wire logic [pta_pkg::DISCARD_W-1:0]   offset_limit,
  output logic                                 snap_ready,
  pta_out_if.source                            out_chan
);
  import pta_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int L  = $clog2(PREGATE);
  localparam int K  = BW + L;
  localparam int RW = BW + 10;
  localparam int PW = BW + RW;
  localparam int AW = BW + 8;
  localparam int OW = (IW > DISCARD_W) ? IW : DISCARD_W;
  // floor(256*sum/PREGATE) == floor(sum*RECIP / 2^K) for every sum below 2^BW.
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << (K + 8)) + 64'(PREGATE) - 64'd1) / PREGATE;
  localparam logic [RW-1:0] RECIP = RW'(RECIP_FULL);

  logic          s2_v_r;
  logic [PW-1:0] prod_r;
  logic [SB-1:0] min2_r;
  logic [IW-1:0] pos2_r;
  logic          pileup2_r;
  logic          short2_r;

  logic             out_v_r;
  logic [AMP_W-1:0] amp_r;
  logic [INDEX_W-1:0] idx_r;
  logic             off_r;
  logic             pil_r;
  logic             sht_r;

  logic                   out_free;
  logic                   s2_free;
  logic [PW-1:0]          prod_nxt;
  logic [PW-1:0]          shifted;
  logic [AW-1:0]          mean_q8;
  logic [AW-1:0]          min_q8;
  logic [AW-1:0]          amp;
  logic [AW+AMP_W-1:0]    amp_ext;
  logic [IW+INDEX_W-1:0]  idx_ext;
  logic                   offset;

  assign out_free   = !out_v_r || out_chan.ready;
  assign s2_free    = !s2_v_r || out_free;
  assign snap_ready = s2_free;

  assign prod_nxt = PW'(snap_sum) * PW'(RECIP);

  always_comb begin
    shifted = prod_r >> K;
    mean_q8 = shifted[AW-1:0];
    min_q8  = AW'({min2_r, 8'h00});
    if (short2_r) begin
      amp = '0;
    end else if (mean_q8 >= min_q8) begin
      amp = mean_q8 - min_q8;
    end else begin
      amp = '0;
    end
    amp_ext = {{AMP_W{1'b0}}, amp};
    idx_ext = {{INDEX_W{1'b0}}, pos2_r};
    offset  = OW'(pos2_r) > OW'(offset_limit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_v_r <= snap.valid;
      end
      if (out_free) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && snap.valid) begin
      prod_r    <= prod_nxt;
      min2_r    <= snap_min;
      pos2_r    <= snap_pos;
      pileup2_r <= snap.pileup;
      short2_r  <= snap.short_tr;
    end
    if (out_free && s2_v_r) begin
      amp_r <= amp_ext[AMP_W-1:0];
      idx_r <= idx_ext[INDEX_W-1:0];
      off_r <= offset;
      pil_r <= pileup2_r;
      sht_r <= short2_r;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.amplitude_q8 = amp_r;
  assign out_chan.min_index    = idx_r;
  assign out_chan.offset_flag  = off_r;
  assign out_chan.pileup_flag  = pil_r;
  assign out_chan.short_trace  = sht_r;

`ifndef SYNTHESIS
  a_short_zero_amp: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && sht_r |-> (amp_r == '0))
    else $error("short trace reported a nonzero amplitude");

  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && out_v_r && !out_chan.ready |=> s2_v_r && $stable(prod_r) && $stable(pos2_r))
    else $error("product stage lost or changed a stalled item");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_chan.ready |=> out_v_r && $stable(amp_r) && $stable(idx_r))
    else $error("stalled result changed before it was taken");
`endif

endmodule

`default_nettype wire

@@ tb/pulse_height_check_pkg.sv @@
// Scoreboard for the pulse amplitude and pileup block: a per-trace predictor and a
// queue of expected results. Depends on pta_pkg for widths, register codes and defaults.
package pulse_height_check_pkg;
  import pta_pkg::*;

  localparam int GAP      = DEF_NEIGHBOUR_GAP;
  localparam int WIN_TAPS = 2 * GAP + 1;

  typedef struct packed {
    logic [AMP_W-1:0]   amplitude_q8;
    logic [INDEX_W-1:0] min_index;
    logic               offset_flag;
    logic               pileup_flag;
    logic               short_trace;
  } pulse_result_t;

  class pulse_height_scoreboard;
    logic [DISCARD_W-1:0]  discard_at;
    logic [DURATION_W-1:0] dip_spacing;
    logic [THRESH_W-1:0]   dip_depth;

    logic [SAMPLE_W-1:0] taps [WIN_TAPS];
    int unsigned         base_acc;
    logic [SAMPLE_W-1:0] trough_val;
    int unsigned         trough_at;
    int unsigned         idx;
    int unsigned         last_dip_at;
    bit                  have_dip;
    bit                  piled;

    pulse_result_t pending_pulses[$];
    int            errors;

    function new();
      errors      = 0;
      discard_at  = RST_OFFSET_LIMIT;
      dip_spacing = RST_PULSE_DURATION;
      dip_depth   = RST_DIP_THRESHOLD;
      clear_trace();
    endfunction

    function void clear_trace();
      foreach (taps[k]) taps[k] = '0;
      base_acc    = 0;
      trough_val  = '1;
      trough_at   = 0;
      idx         = 0;
      last_dip_at = 0;
      have_dip    = 1'b0;
      piled       = 1'b0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_OFFSET_LIMIT:   discard_at  = data[DISCARD_W-1:0];
        REG_PULSE_DURATION: dip_spacing = data[DURATION_W-1:0];
        REG_DIP_THRESHOLD:  dip_depth   = data[THRESH_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_pulses.size();
    endfunction

    // Advances the trace state by one accepted sample; the last one queues a result.
    function void note_sample(logic [SAMPLE_W-1:0] s, logic last);
      int unsigned      n;
      int               centre;
      int               left_v;
      int               right_v;
      int unsigned      pos;
      longint unsigned  mean_q8;
      longint unsigned  floor_q8;
      pulse_result_t    r;
      n = idx;
      for (int k = WIN_TAPS - 1; k > 0; k--) taps[k] = taps[k-1];
      taps[0] = s;
      if (n < DEF_PREGATE) base_acc += s;
      if (s < trough_val) begin
        trough_val = s;
        trough_at  = n;
      end
      // A dip is only tested once both neighbours lie inside the trace.
      if (n >= 2 * GAP && !piled) begin
        centre  = taps[GAP];
        left_v  = taps[2*GAP];
        right_v = taps[0];
        if ((left_v - centre) > int'(dip_depth) && (right_v - centre) > int'(dip_depth)) begin
          pos = n - GAP;
          if (have_dip && (pos - last_dip_at) > dip_spacing) piled = 1'b1;
          last_dip_at = pos;
          have_dip    = 1'b1;
        end
      end
      if (n < DEF_TRACE_CAP - 1) idx = n + 1;
      if (!last) return;
      r.short_trace  = (n + 1) < DEF_PREGATE;
      r.amplitude_q8 = '0;
      if (!r.short_trace) begin
        mean_q8  = (64'(base_acc) * 256) / DEF_PREGATE;
        floor_q8 = 64'(trough_val) << 8;
        if (mean_q8 >= floor_q8) r.amplitude_q8 = AMP_W'(mean_q8 - floor_q8);
      end
      r.min_index   = trough_at[INDEX_W-1:0];
      r.offset_flag = trough_at > discard_at;
      r.pileup_flag = piled;
      pending_pulses.push_back(r);
      clear_trace();
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(pulse_result_t got);
      pulse_result_t want;
      if (pending_pulses.size() == 0) begin
        $error("result with no trace pending: amplitude_q8 %0d, min_index %0d",
               got.amplitude_q8, got.min_index);
        errors++;
        return;
      end
      want = pending_pulses.pop_front();
      compare_field("amplitude_q8", want.amplitude_q8, got.amplitude_q8);
      compare_field("min_index", want.min_index, got.min_index);
      compare_field("offset_flag", want.offset_flag, got.offset_flag);
      compare_field("pileup_flag", want.pileup_flag, got.pileup_flag);
      compare_field("short_trace", want.short_trace, got.short_trace);
    endfunction
  endclass

endpackage

@@ tb/pulse_trace_amplitude_pileup_test.sv @@
// Top of the testbench: clock, reset, sample sender, result receiver, monitor and watchdog.
// Depends on pta_pkg, pta_if, pulse_height_check_pkg and the pulse_trace_amplitude_pileup RTL.
module pulse_trace_amplitude_pileup_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pta_pkg::*;
  import pulse_height_check_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 4000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 225;
  localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pta_in_if  in_chan ();
  pta_out_if out_chan ();

  pulse_trace_amplitude_pileup dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pulse_height_scoreboard board = new();

  bit            quiet;
  bit            hold_req;
  int            sent_count;
  int            idle_cycles;
  pulse_result_t seen;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one; none at all during a quiet phase.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(1, 24);
    if (r < 20) begin
      case ($urandom_range(0, 3))
        0: return 12;
        1: return 13;
        2: return DEF_PREGATE - 1;
        default: return DEF_PREGATE;
      endcase
    end
    return $urandom_range(26, 150);
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid       = 1'b1;
    in_chan.sample      = value;
    in_chan.last_sample = last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  // A baseline with noise and up to two triangular pulses, or pure noise.
  // With late set, the first pulse sits in the last four samples of the trace.
  task automatic send_trace(input int len, input bit noisy, input bit late);
    int base, noise, depth1, depth2, at1, at2, wid, v, d;
    base   = $urandom_range(0, SAMPLE_MAX);
    noise  = $urandom_range(0, 30);
    depth1 = $urandom_range(0, base);
    depth2 = $urandom_range(0, base);
    wid    = $urandom_range(1, 12);
    at1    = late ? len - 1 - $urandom_range(0, 3) : $urandom_range(0, len - 1);
    at2    = at1 + $urandom_range(1, 120);
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        v = $urandom_range(0, SAMPLE_MAX);
      end else begin
        v = base + int'($urandom_range(0, noise)) - noise / 2;
        d = (i > at1) ? i - at1 : at1 - i;
        if (d < wid) v -= depth1 * (wid - d) / wid;
        d = (i > at2) ? i - at2 : at2 - i;
        if (d < wid) v -= depth2 * (wid - d) / wid;
        if (v < 0) v = 0;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      end
      send_sample(v[SAMPLE_W-1:0], i == len - 1);
    end
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] index, input int value);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    board.write_reg(index, value[CFG_DATA_W-1:0]);
  endtask

  // Stops sending and waits until no result is pending, then lets the block settle.
  task automatic wait_drained();
    in_chan.valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input int phase);
    case (phase)
      1: begin
        write_reg(REG_OFFSET_LIMIT, 0);
        write_reg(REG_PULSE_DURATION, 0);
        write_reg(REG_DIP_THRESHOLD, 0);
      end
      2: begin
        write_reg(REG_OFFSET_LIMIT, (1 << DISCARD_W) - 1);
        write_reg(REG_PULSE_DURATION, (1 << DURATION_W) - 1);
        write_reg(REG_DIP_THRESHOLD, (1 << THRESH_W) - 1);
      end
      default: begin
        write_reg(REG_OFFSET_LIMIT, $urandom_range(0, 160));
        write_reg(REG_PULSE_DURATION, $urandom_range(0, 80));
        write_reg(REG_DIP_THRESHOLD, $urandom_range(0, 400));
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) board.note_sample(in_chan.sample, in_chan.last_sample);
      if (out_chan.valid && out_chan.ready) begin
        seen.amplitude_q8 = out_chan.amplitude_q8;
        seen.min_index    = out_chan.min_index;
        seen.offset_flag  = out_chan.offset_flag;
        seen.pileup_flag  = out_chan.pileup_flag;
        seen.short_trace  = out_chan.short_trace;
        board.check_result(seen);
      end
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off when the sender asks for it.
  initial begin
    int stall;
    stall          = 0;
    out_chan.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_chan.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req       = 1'b0;
        out_chan.ready = 1'b1;
      end else if (stall > 0) begin
        out_chan.ready = 1'b0;
        stall--;
      end else begin
        out_chan.ready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  initial begin
    int target;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = REG_OFFSET_LIMIT;
    cfg_data            = '0;
    in_chan.valid       = 1'b0;
    in_chan.sample      = '0;
    in_chan.last_sample = 1'b0;
    quiet               = 1'b0;
    hold_req            = 1'b0;
    sent_count          = 0;
    idle_cycles         = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Single-sample traces at both extremes of the sample range.
    send_sample(SAMPLE_W'(SAMPLE_MAX), 1'b1);
    send_sample('0, 1'b1);
    // Thirteen samples: the centre sits one count past the default threshold,
    // then exactly at it, so only the first trace sees a dip.
    for (int i = 0; i < 13; i++) send_sample((i == 6) ? 14'd1000 : 14'd1051, i == 12);
    for (int i = 0; i < 13; i++) send_sample((i == 6) ? 14'd1000 : 14'd1050, i == 12);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        wait_drained();
        configure(phase);
      end
      quiet = (phase == 3);
      if (phase == 5) begin
        // Stall the results while short traces keep coming so the block backs up.
        hold_req = 1'b1;
        repeat (40) send_trace($urandom_range(1, 3), 1'b0, 1'b0);
        wait_drained();
      end
      if (phase == 6) send_trace(pick_len(), 1'b0, 1'b1);
      target = sent_count + PHASE_ITEMS;
      while (sent_count < target) send_trace(pick_len(), $urandom_range(0, 6) == 0, 1'b0);
    end

    wait_drained();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
